@@ rtl/core/cawt_pkg.sv @@
// Shared types and constants for the client ack window tracker.
package cawt_pkg;

	localparam logic [2:0] OP_CONNECT    = 3'd0;
	localparam logic [2:0] OP_DISCONNECT = 3'd1;
	localparam logic [2:0] OP_PING       = 3'd2;
	localparam logic [2:0] OP_STATS      = 3'd3;

	localparam logic [1:0] KIND_VERDICT = 2'd0;
	localparam logic [1:0] KIND_PONG    = 2'd1;
	localparam logic [1:0] KIND_STATS   = 2'd2;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 216;

	typedef struct packed {
		logic [15:0] newest;
		logic [31:0] out_seq;
		logic [31:0] received;
		logic [31:0] dropped;
		logic [31:0] late;
	} entry_cnt_t;

endpackage

@@ rtl/core/cawt_track.sv @@
// Ack window update and counter bookkeeping for one message of one client.
module cawt_track #(
	parameter int WINDOW_BITS = 32
) (
	input  logic [WINDOW_BITS-1:0] window,
	input  cawt_pkg::entry_cnt_t   cnt,
	input  logic [15:0]            seq_id,
	output logic [WINDOW_BITS-1:0] window_next,
	output cawt_pkg::entry_cnt_t   cnt_next
);
	import cawt_pkg::*;

	localparam int SW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
	localparam int CW = $clog2(WINDOW_BITS + 1);
	localparam logic [15:0] WLIM = 16'(WINDOW_BITS);
	localparam logic [WINDOW_BITS-1:0] ONES = '1;
	localparam logic [WINDOW_BITS-1:0] ONE = WINDOW_BITS'(1);

	logic                   ahead;
	logic                   behind;
	logic [15:0]            fwd;
	logic [15:0]            back;
	logic [15:0]            fwd_m1;
	logic [15:0]            back_m1;
	logic                   fwd_in;
	logic                   fwd_set;
	logic                   back_in;
	logic [WINDOW_BITS-1:0] leave_mask;
	logic [WINDOW_BITS-1:0] lost_vec;
	logic [CW-1:0]          lost_cnt;
	logic [WINDOW_BITS-1:0] shifted;
	logic [WINDOW_BITS-1:0] set_fwd;

	assign ahead   = seq_id > cnt.newest;
	assign behind  = seq_id < cnt.newest;
	assign fwd     = seq_id - cnt.newest;
	assign back    = cnt.newest - seq_id;
	assign fwd_m1  = fwd - 16'd1;
	assign back_m1 = back - 16'd1;
	assign fwd_in  = fwd < WLIM;
	assign fwd_set = fwd <= WLIM;
	assign back_in = back <= WLIM;

	// Bits that fall off the top of the window on a forward jump.
	assign leave_mask = fwd_in ? ~(ONES >> fwd[SW-1:0]) : ONES;
	assign lost_vec   = ~window & leave_mask;
	assign lost_cnt   = CW'($countones(lost_vec));
	assign shifted    = fwd_in ? (window << fwd[SW-1:0]) : '0;
	assign set_fwd    = fwd_set ? (ONE << fwd_m1[SW-1:0]) : '0;

	always_comb begin
		cnt_next = cnt;
		window_next = window;
		cnt_next.received = cnt.received + 32'd1;
		if (behind) begin
			cnt_next.late = cnt.late + 32'd1;
			if (back_in) begin
				window_next = window | (ONE << back_m1[SW-1:0]);
			end
		end else if (ahead) begin
			cnt_next.dropped = cnt.dropped + 32'(lost_cnt);
			window_next = shifted | set_fwd;
			cnt_next.newest = seq_id;
		end
	end

endmodule

@@ rtl/core/client_ack_window_tracker.sv @@
// Top level of the client ack window tracker: client table, input stage and result register.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   opcode[2:0], client_key[34:3], seq_id[50:35]
// m_axis    out  reply_kind[1:0], reply_client[33:2], ack_bits[65:34], newest_seen[81:66],
//                reply_seq[113:82], received_count[145:114], dropped_count[177:146],
//                late_count[209:178]
//
// An item is held in the input stage, where the table lookup, window update and
// counter updates happen, and its result is then registered in the output register.
// One item is accepted per cycle while the output register is free or being drained.
// The table lookup and write-back close in the same cycle, so each item sees the
// updates of the one before it. Reset clears all valid bits and both stage flags.
// A waiting result stalls the input stage, which holds one more item.
module client_ack_window_tracker #(
	parameter int CLIENT_SLOTS = 16,
	parameter int WINDOW_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// opcode, client_key, seq_id, zero fill
	input  logic [cawt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// reply_kind, reply_client, ack_bits, newest_seen, reply_seq, received_count,
	// dropped_count, late_count, zero fill
	output logic [cawt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import cawt_pkg::*;

	localparam int IDX_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam logic [WINDOW_BITS-1:0] ONES = '1;

	logic                   valid_s1;
	logic [2:0]             opcode_s1;
	logic [31:0]            key_s1;
	logic [15:0]            seq_s1;

	logic                   entry_valid_q [CLIENT_SLOTS];
	logic [31:0]            entry_key_q [CLIENT_SLOTS];
	logic [WINDOW_BITS-1:0] entry_window_q [CLIENT_SLOTS];
	entry_cnt_t             entry_cnt_q [CLIENT_SLOTS];

	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	logic                   in_accept;
	logic                   go;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   free;
	logic [IDX_W-1:0]       free_idx;
	logic                   is_connect;
	logic                   is_disc;
	logic                   fresh;
	logic                   tracked;
	logic                   emit;
	logic [IDX_W-1:0]       slot;
	logic [WINDOW_BITS-1:0] cur_win;
	entry_cnt_t             cur_cnt;
	logic [WINDOW_BITS-1:0] win_next;
	entry_cnt_t             cnt_next;
	entry_cnt_t             cnt_wr;
	logic [1:0]             kind;
	logic [31:0]            rep_received;
	logic [31:0]            rep_dropped;
	logic [31:0]            rep_late;

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign go            = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1 <= s_axis_tdata[2:0];
			key_s1 <= s_axis_tdata[34:3];
			seq_s1 <= s_axis_tdata[50:35];
		end
	end

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free = 1'b0;
		free_idx = '0;
		for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
			if (entry_valid_q[i] && entry_key_q[i] == key_s1) begin
				hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!entry_valid_q[i]) begin
				free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign is_connect = opcode_s1 == OP_CONNECT;
	assign is_disc    = opcode_s1 == OP_DISCONNECT;
	assign fresh      = is_connect && !hit && free;
	assign slot       = hit ? hit_idx : free_idx;
	assign tracked    = valid_s1 && ((hit && !is_disc) || fresh);
	assign emit       = tracked && (is_connect || opcode_s1 == OP_PING || opcode_s1 == OP_STATS);

	always_comb begin
		if (fresh) begin
			cur_win = ONES;
			cur_cnt = '{newest: seq_s1, default: '0};
		end else begin
			cur_win = entry_window_q[slot];
			cur_cnt = entry_cnt_q[slot];
		end
	end

	cawt_track #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_track (
		.window     (cur_win),
		.cnt        (cur_cnt),
		.seq_id     (seq_s1),
		.window_next(win_next),
		.cnt_next   (cnt_next)
	);

	always_comb begin
		cnt_wr = cnt_next;
		cnt_wr.out_seq = cnt_next.out_seq + 32'(emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLIENT_SLOTS; i++) begin
				entry_valid_q[i] <= 1'b0;
			end
		end else if (go) begin
			if (fresh) begin
				entry_valid_q[slot] <= 1'b1;
			end else if (is_disc && hit) begin
				entry_valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && tracked) begin
			entry_window_q[slot] <= win_next;
			entry_cnt_q[slot] <= cnt_wr;
			if (fresh) begin
				entry_key_q[slot] <= key_s1;
			end
		end
	end

	always_comb begin
		case (opcode_s1)
			OP_CONNECT: kind = KIND_VERDICT;
			OP_PING:    kind = KIND_PONG;
			default:    kind = KIND_STATS;
		endcase
	end

	assign rep_received = (kind == KIND_STATS) ? cnt_next.received : 32'd0;
	assign rep_dropped  = (kind == KIND_STATS) ? cnt_next.dropped : 32'd0;
	assign rep_late     = (kind == KIND_STATS) ? cnt_next.late : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_data_q <= {6'd0, rep_late, rep_dropped, rep_received, cur_cnt.out_seq,
				cnt_next.newest, 32'(win_next), key_s1, kind};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(go && fresh) |=> entry_valid_q[$past(free_idx)])
		else $error("New connection did not take its slot.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(go && is_disc && hit) |=> !entry_valid_q[$past(hit_idx)])
		else $error("Disconnect left the entry valid.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go && emit))
		else $error("Result appeared without a reply-producing transaction.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |=> (valid_s1 && $stable(key_s1)))
		else $error("Input stage moved while the result register was blocked.");

endmodule
